FILE: hw/rtl/scc_pkg.sv
// Package for the seven-bit chunk codec: item types, command format between
// the front and back halves, and chunk constants. No dependencies.
`timescale 1ns / 1ps

package scc_pkg;

  // Payload bytes per chunk, and widths that follow from it
  localparam int unsigned ChunkLen = 7;
  localparam int unsigned PosW     = 3;
  localparam int unsigned LowW     = 7;

  // Low seven bits of a byte
  localparam logic [7:0] LowMask  = 8'h7F;
  localparam logic [7:0] HighMask = 8'h80;

  // Direction register codes
  localparam logic DirEncode = 1'b0;
  localparam logic DirDecode = 1'b1;

  // Last chunk position, as a position value
  localparam logic [PosW-1:0] PosFull = PosW'(ChunkLen);

  typedef struct packed {
    logic [7:0] data_in;
    logic       last_in;
  } in_item_t;

  typedef struct packed {
    logic [7:0] data_out;
    logic       run_last;
    logic       message_end;
    logic       chunk_error;
  } out_item_t;

  // Work orders handed from the front to the back
  typedef enum logic [1:0] {
    CMD_ENC_BYTE,   // one payload byte, chunk continues
    CMD_ENC_FLUSH,  // payload byte, padding zeros, then the MSB byte
    CMD_DEC_CHUNK,  // seven restored bytes
    CMD_DEC_ERROR   // message ended inside a chunk
  } cmd_kind_e;

  typedef struct packed {
    cmd_kind_e                     kind;
    logic                          last;  // input carried last_in
    logic [PosW-1:0]               pad;   // padding zeros before the MSB byte
    logic [LowW-1:0]               msb;   // collected or received MSBs
    logic [ChunkLen-1:0][LowW-1:0] lows;  // payload low bits, entry 0 first
  } cmd_t;

endpackage

FILE: hw/rtl/seven_bit_chunk_codec.sv
// Seven-bit chunk codec, top level: joins front, command queue and back.
// Depends on scc_pkg, scc_front, scc_cmd_queue and scc_back.
//
// Usage:
//   Input is a queue write port: an item {data_in, last_in} transfers at a
//   clock edge with push high and full low. Results are a queue read port:
//   the oldest result sits on out_o while empty is low and transfers at an
//   edge with pop high. cfg_we_i loads the direction bit (0 encode, 1 decode)
//   and drops any partial chunk; write it only while the block is drained.
// Timing:
//   One item can transfer per cycle while full is low. Its command is
//   registered in the command queue and its results in the result queue,
//   which feeds out_o. The back end emits one result per cycle while the
//   result queue has room, so a chunk end holds it for all of its results
//   (two for a full encode chunk, up to eight for a padded final chunk, seven
//   when decoding); the two-entry command queue takes one more item behind
//   the busy command, then full rises. Encoding 7 bytes gives 8 results.
// Reset: clears direction to encode, chunk progress and both queues.
// If pop stays low, the result queue fills, then the command queue, then
// full rises; nothing is dropped.
`timescale 1ns / 1ps

module seven_bit_chunk_codec (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic               cfg_wdata_i,
  input  logic               push,
  input  scc_pkg::in_item_t  in_i,
  output logic               full,
  input  logic               pop,
  output logic               empty,
  output scc_pkg::out_item_t out_o
);
  import scc_pkg::*;

  logic       accept;
  logic       cmd_push, cmd_pop, cmd_empty;
  cmd_t       cmd_in, cmd_out;
  logic [2:0] back_idx;

  assign accept = push && !full;

  scc_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .accept_i    (accept),
    .item_i      (in_i),
    .cmd_push_o  (cmd_push),
    .cmd_o       (cmd_in)
  );

  scc_cmd_queue u_cmd_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (cmd_push),
    .cmd_i   (cmd_in),
    .full_o  (full),
    .pop_i   (cmd_pop),
    .empty_o (cmd_empty),
    .cmd_o   (cmd_out)
  );

  scc_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_empty_i (cmd_empty),
    .cmd_i       (cmd_out),
    .cmd_pop_o   (cmd_pop),
    .idx_o       (back_idx),
    .pop_i       (pop),
    .empty_o     (empty),
    .res_o       (out_o)
  );

  // Checks

  // An error result is a lone zero byte that ends its message
  a_error_form: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && out_o.chunk_error) |->
      (out_o.run_last && out_o.message_end && out_o.data_out == 8'h00))
    else $error("chunk error result malformed");

  // Message end only on the final result of an input
  a_end_is_run_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && out_o.message_end) |-> out_o.run_last)
    else $error("message_end without run_last");

  // Single-result commands never advance the step counter
  a_single_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!cmd_empty && (cmd_out.kind == CMD_ENC_BYTE || cmd_out.kind == CMD_DEC_ERROR))
      |-> (back_idx == 3'd0))
    else $error("step counter moved on a single-result command");

  // A flush pads six zeros at most, and its step never passes the MSB byte
  a_pad_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!cmd_empty && cmd_out.kind == CMD_ENC_FLUSH) |->
      (cmd_out.pad <= 3'd6 && back_idx <= cmd_out.pad + 3'd1))
    else $error("flush padding out of range");

endmodule

FILE: hw/rtl/scc_front.sv
// Front half of the seven-bit chunk codec: takes input bytes, tracks chunk
// progress and buffers, and issues commands. Depends on scc_pkg.
`timescale 1ns / 1ps

module scc_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic              cfg_wdata_i,
  input  logic              accept_i,
  input  scc_pkg::in_item_t item_i,
  output logic              cmd_push_o,
  output scc_pkg::cmd_t     cmd_o
);
  import scc_pkg::*;

  logic                 dir_q;
  logic [PosW-1:0]      pos_q, pos_d;
  logic [LowW-1:0]      msb_q, msb_d;
  logic [LowW-1:0]      low_q [ChunkLen];
  logic                 pos_open;
  logic [PosW-1:0]      pos_inc;
  logic [LowW-1:0]      msb_set;
  logic                 enc_end;

  assign pos_open = (pos_q != PosFull);
  assign pos_inc  = pos_open ? (pos_q + PosW'(1)) : pos_q;

  // MSB of this byte lands at the current chunk position
  always_comb begin
    msb_set = msb_q;
    if (pos_open && item_i.data_in[7]) begin
      msb_set[pos_q] = 1'b1;
    end
  end

  assign enc_end = (pos_inc == PosFull) || item_i.last_in;

  // Classify the item and build its command
  always_comb begin
    pos_d      = pos_q;
    msb_d      = msb_q;
    cmd_push_o = 1'b0;
    cmd_o.kind = CMD_ENC_BYTE;
    cmd_o.last = item_i.last_in;
    cmd_o.pad  = PosFull - pos_inc;
    cmd_o.msb  = msb_set;
    for (int i = 0; i < ChunkLen; i++) begin
      cmd_o.lows[i] = low_q[i];
    end
    if (dir_q == DirEncode) begin
      cmd_o.lows[0] = item_i.data_in[LowW-1:0];
      cmd_push_o    = accept_i;
      if (enc_end) begin
        cmd_o.kind = CMD_ENC_FLUSH;
        pos_d      = '0;
        msb_d      = '0;
      end else begin
        pos_d = pos_inc;
        msb_d = msb_set;
      end
    end else begin
      cmd_o.msb = item_i.data_in[LowW-1:0];
      if (!pos_open) begin
        cmd_o.kind = CMD_DEC_CHUNK;
        cmd_push_o = accept_i;
        pos_d      = '0;
      end else if (item_i.last_in) begin
        cmd_o.kind = CMD_DEC_ERROR;
        cmd_push_o = accept_i;
        pos_d      = '0;
      end else begin
        pos_d = pos_inc;
      end
    end
  end

  // Control state; a config write abandons any partial chunk
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dir_q <= DirEncode;
      pos_q <= '0;
      msb_q <= '0;
    end else if (cfg_we_i) begin
      dir_q <= cfg_wdata_i;
      pos_q <= '0;
      msb_q <= '0;
    end else if (accept_i) begin
      pos_q <= pos_d;
      msb_q <= msb_d;
    end
  end

  // Decode payload buffer, written at the chunk position
  always_ff @(posedge clk_i) begin
    if (accept_i && (dir_q == DirDecode) && pos_open) begin
      low_q[pos_q] <= item_i.data_in[LowW-1:0];
    end
  end

endmodule

FILE: hw/rtl/scc_cmd_queue.sv
// Two-entry command queue between the front and back halves of the
// seven-bit chunk codec. Depends on scc_pkg.
`timescale 1ns / 1ps

module scc_cmd_queue (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  scc_pkg::cmd_t cmd_i,
  output logic          full_o,
  input  logic          pop_i,
  output logic          empty_o,
  output scc_pkg::cmd_t cmd_o
);
  import scc_pkg::*;

  cmd_t       mem_q [2];
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] count_q;
  logic       do_push, do_pop;

  assign full_o  = (count_q == 2'd2);
  assign empty_o = (count_q == 2'd0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign cmd_o   = mem_q[rd_ptr_q];

  // Pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= !wr_ptr_q;
      end
      if (do_pop) begin
        rd_ptr_q <= !rd_ptr_q;
      end
      if (do_push && !do_pop) begin
        count_q <= count_q + 2'd1;
      end else if (do_pop && !do_push) begin
        count_q <= count_q - 2'd1;
      end
    end
  end

  // Storage
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= cmd_i;
    end
  end

endmodule

FILE: hw/rtl/scc_back.sv
// Back half of the seven-bit chunk codec; depends on scc_pkg. Expands each
// command to bytes of a two-entry result queue, one per cycle unless full.
`timescale 1ns / 1ps

module scc_back (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cmd_empty_i,
  input  scc_pkg::cmd_t       cmd_i,
  output logic                cmd_pop_o,
  output logic [2:0]          idx_o,
  input  logic                pop_i,
  output logic                empty_o,
  output scc_pkg::out_item_t  res_o
);
  import scc_pkg::*;

  logic [PosW-1:0] idx_q;
  out_item_t       res;
  logic            res_push;
  out_item_t       mem_q [2];
  logic            wr_ptr_q, rd_ptr_q;
  logic [1:0]      count_q;
  logic            res_full, res_pop;

  assign idx_o = idx_q;

  // Result byte for the current step of the command
  always_comb begin
    res.data_out    = '0;
    res.run_last    = 1'b0;
    res.chunk_error = 1'b0;
    unique case (cmd_i.kind)
      CMD_ENC_BYTE: begin
        res.data_out = {1'b0, cmd_i.lows[0]};
        res.run_last = 1'b1;
      end
      CMD_ENC_FLUSH: begin
        if (idx_q == '0) begin
          res.data_out = {1'b0, cmd_i.lows[0]};
        end else if (idx_q > cmd_i.pad) begin
          res.data_out = {1'b0, cmd_i.msb};
        end
        res.run_last = ({1'b0, idx_q} == ({1'b0, cmd_i.pad} + 4'd1));
      end
      CMD_DEC_CHUNK: begin
        res.data_out = {cmd_i.msb[idx_q], cmd_i.lows[idx_q]};
        res.run_last = (idx_q == PosW'(ChunkLen - 1));
      end
      CMD_DEC_ERROR: begin
        res.run_last    = 1'b1;
        res.chunk_error = 1'b1;
      end
      default: ;
    endcase
    res.message_end = res.run_last && cmd_i.last;
  end

  assign res_full  = (count_q == 2'd2);
  assign res_push  = !cmd_empty_i && !res_full;
  assign cmd_pop_o = res_push && res.run_last;

  // Step counter within a command
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q <= '0;
    end else if (res_push) begin
      idx_q <= res.run_last ? '0 : (idx_q + PosW'(1));
    end
  end

  // Result queue control
  assign empty_o = (count_q == 2'd0);
  assign res_pop = pop_i && !empty_o;
  assign res_o   = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      if (res_push) begin
        wr_ptr_q <= !wr_ptr_q;
      end
      if (res_pop) begin
        rd_ptr_q <= !rd_ptr_q;
      end
      if (res_push && !res_pop) begin
        count_q <= count_q + 2'd1;
      end else if (res_pop && !res_push) begin
        count_q <= count_q - 2'd1;
      end
    end
  end

  // Result storage
  always_ff @(posedge clk_i) begin
    if (res_push) begin
      mem_q[wr_ptr_q] <= res;
    end
  end

endmodule
